/* rtl/slfr_pkg.sv */
package slfr_pkg;

  localparam int BUF_BYTES_DEF = 64;
  localparam int LENGTH_POS_DEF = 1;

  localparam logic [15:0] SYNC_RESET = 16'hAAAF;
  localparam logic [8:0] LEN_EXTRA = 9'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic       byte_stored;
    logic [7:0] store_index;
    logic [7:0] stored_byte;
    logic       frame_done;
    logic       frame_dropped;
    logic       ignored_busy;
    logic       in_frame;
  } result_t;

endpackage

/* rtl/slfr_if.sv */
interface slfr_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface slfr_result_if;
  logic       valid;
  logic       ready;
  logic       byte_stored;
  logic [7:0] store_index;
  logic [7:0] stored_byte;
  logic       frame_done;
  logic       frame_dropped;
  logic       ignored_busy;
  logic       in_frame;

  modport source (
    output valid, output byte_stored, output store_index, output stored_byte,
    output frame_done, output frame_dropped, output ignored_busy, output in_frame,
    input ready
  );
  modport sink (
    input valid, input byte_stored, input store_index, input stored_byte,
    input frame_done, input frame_dropped, input ignored_busy, input in_frame,
    output ready
  );
endinterface

interface slfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/slfr_core.sv */
module slfr_core #(
  parameter int BUF_BYTES = slfr_pkg::BUF_BYTES_DEF,
  parameter int LENGTH_POS = slfr_pkg::LENGTH_POS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              opcode,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       sync_word,
  output slfr_pkg::result_t result
);

  localparam logic [7:0] LenPos = 8'(LENGTH_POS);
  localparam logic [8:0] BufLimit = 9'(BUF_BYTES);

  logic [15:0] header_shift, header_shift_next;
  logic        receiving, receiving_next;
  logic        ready_hold, ready_hold_next;
  logic [7:0]  write_index, write_index_next;
  logic [7:0]  frame_length, frame_length_next;
  logic        length_seen, length_seen_next;

  logic [15:0] shifted;
  logic [8:0]  count_next;
  logic        capture;
  logic [7:0]  length_eff;
  logic        seen_eff;
  logic        complete;

  assign shifted = {header_shift[7:0], rx_byte};
  assign count_next = {1'b0, write_index} + 9'd1;
  assign capture = (write_index == LenPos);
  assign length_eff = capture ? rx_byte : frame_length;
  assign seen_eff = length_seen || capture;
  assign complete = seen_eff && (count_next > ({1'b0, length_eff} + slfr_pkg::LEN_EXTRA));

  always_comb begin
    header_shift_next = header_shift;
    receiving_next = receiving;
    ready_hold_next = ready_hold;
    write_index_next = write_index;
    frame_length_next = frame_length;
    length_seen_next = length_seen;
    result = '0;

    priority if (opcode == slfr_pkg::OP_RELEASE) begin
      ready_hold_next = 1'b0;
    end else if (ready_hold) begin
      result.ignored_busy = 1'b1;
    end else if (receiving) begin
      result.byte_stored = 1'b1;
      result.store_index = write_index;
      result.stored_byte = rx_byte;
      if (capture) begin
        frame_length_next = rx_byte;
        length_seen_next = 1'b1;
      end
      if (complete) begin
        result.frame_done = 1'b1;
        ready_hold_next = 1'b1;
        receiving_next = 1'b0;
        length_seen_next = 1'b0;
        write_index_next = '0;
      end else if (count_next >= BufLimit) begin
        result.frame_dropped = 1'b1;
        receiving_next = 1'b0;
        length_seen_next = 1'b0;
        write_index_next = '0;
      end else begin
        write_index_next = count_next[7:0];
      end
    end else begin
      header_shift_next = shifted;
      if (shifted == sync_word) begin
        receiving_next = 1'b1;
        write_index_next = '0;
        length_seen_next = 1'b0;
      end
    end

    result.in_frame = receiving_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift <= '0;
      receiving <= 1'b0;
      ready_hold <= 1'b0;
      write_index <= '0;
      frame_length <= '0;
      length_seen <= 1'b0;
    end else if (step) begin
      header_shift <= header_shift_next;
      receiving <= receiving_next;
      ready_hold <= ready_hold_next;
      write_index <= write_index_next;
      frame_length <= frame_length_next;
      length_seen <= length_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_excl_state: assert property (@(posedge clk) disable iff (rst)
    !(receiving && ready_hold))
    else $error("Frame reception active while a completed frame waits.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, write_index} < BufLimit)
    else $error("Write index beyond buffer capacity.");

  a_done_sets_hold: assert property (@(posedge clk) disable iff (rst)
    step && result.frame_done |=> ready_hold && !receiving)
    else $error("Completed frame did not raise the ready flag.");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !receiving |-> write_index == '0 && !length_seen)
    else $error("Stale frame state while not receiving.");
`endif

endmodule

/* rtl/sync_length_frame_receiver.sv */
// Channel  Role  Payload
// item     sink  opcode, rx_byte
// result   src   byte_stored, store_index, stored_byte, frame_done,
//                frame_dropped, ignored_busy, in_frame
// cfg      sink  data (sync word, first byte in the high half)
//
// The frame state updates on the accepting edge and the result lands in the
// output register, visible in the next cycle.
// The input is ready whenever the output register is empty or being taken.
// The cfg channel is always ready; the sync word loads whenever cfg.valid is high.
// Reset is synchronous and returns the sync word to its default and the frame
// state to idle.
module sync_length_frame_receiver #(
  parameter int BUF_BYTES = slfr_pkg::BUF_BYTES_DEF,
  parameter int LENGTH_POS = slfr_pkg::LENGTH_POS_DEF
) (
  input logic           clk,
  input logic           rst,
  slfr_item_if.sink     item,
  slfr_result_if.source result,
  slfr_cfg_if.sink      cfg
);

  logic [15:0]       sync_word;
  logic              accept;
  logic              res_valid;
  slfr_pkg::result_t step_result;
  slfr_pkg::result_t res_data;

  assign item.ready = !res_valid || result.ready;
  assign accept = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= slfr_pkg::SYNC_RESET;
    end else if (cfg.valid) begin
      sync_word <= cfg.data;
    end
  end

  slfr_core #(
    .BUF_BYTES(BUF_BYTES),
    .LENGTH_POS(LENGTH_POS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(accept),
    .opcode(item.opcode),
    .rx_byte(item.rx_byte),
    .sync_word(sync_word),
    .result(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= step_result;
    end
  end

  assign result.valid = res_valid;
  assign result.byte_stored = res_data.byte_stored;
  assign result.store_index = res_data.store_index;
  assign result.stored_byte = res_data.stored_byte;
  assign result.frame_done = res_data.frame_done;
  assign result.frame_dropped = res_data.frame_dropped;
  assign result.ignored_busy = res_data.ignored_busy;
  assign result.in_frame = res_data.in_frame;

endmodule

/* bench/slfr_checker.sv */
`timescale 1ns / 100ps
module slfr_checker #(
  parameter int BUF_BYTES = slfr_pkg::BUF_BYTES_DEF,
  parameter int LENGTH_POS = slfr_pkg::LENGTH_POS_DEF
) (
  input logic    clk,
  input logic    rst,
  slfr_item_if   item,
  slfr_result_if result,
  slfr_cfg_if    cfg,
  output int     fail_count,
  output int     outstanding,
  output int     frames_done,
  output int     frames_dropped
);

  localparam int MAX_PRINTED = 40;

  logic [15:0]       sync_reg;
  logic [15:0]       hdr_shift;
  logic              in_body;
  logic              frame_held;
  logic              len_known;
  logic [7:0]        wr_idx;
  logic [7:0]        len_byte;
  slfr_pkg::result_t frame_results_q[$];

  task automatic report(input string what, input logic [7:0] got_v, input logic [7:0] exp_v);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("%0t: mismatch on %s, got %0h expected %0h", $time, what, got_v, exp_v);
    end
  endtask

  function automatic slfr_pkg::result_t deframe_item(input logic op, input logic [7:0] b);
    slfr_pkg::result_t r;
    logic [8:0]        next;
    r = '0;
    if (op == slfr_pkg::OP_RELEASE) begin
      frame_held = 1'b0;
    end else if (frame_held) begin
      r.ignored_busy = 1'b1;
    end else if (in_body) begin
      r.byte_stored = 1'b1;
      r.store_index = wr_idx;
      r.stored_byte = b;
      if (wr_idx == LENGTH_POS) begin
        len_byte = b;
        len_known = 1'b1;
      end
      next = {1'b0, wr_idx} + 9'd1;
      if (len_known && next > {1'b0, len_byte} + slfr_pkg::LEN_EXTRA) begin
        r.frame_done = 1'b1;
        frame_held = 1'b1;
        in_body = 1'b0;
        len_known = 1'b0;
        wr_idx = '0;
      end else if (next >= BUF_BYTES) begin
        r.frame_dropped = 1'b1;
        in_body = 1'b0;
        len_known = 1'b0;
        wr_idx = '0;
      end else begin
        wr_idx = next[7:0];
      end
    end else begin
      hdr_shift = {hdr_shift[7:0], b};
      if (hdr_shift == sync_reg) begin
        in_body = 1'b1;
        wr_idx = '0;
        len_known = 1'b0;
      end
    end
    r.in_frame = in_body;
    return r;
  endfunction

  always @(posedge clk) begin
    slfr_pkg::result_t want;
    if (rst) begin
      sync_reg = slfr_pkg::SYNC_RESET;
      hdr_shift = '0;
      in_body = 1'b0;
      frame_held = 1'b0;
      len_known = 1'b0;
      wr_idx = '0;
      len_byte = '0;
      frame_results_q.delete();
      fail_count = 0;
      frames_done = 0;
      frames_dropped = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        sync_reg = cfg.data;
      end
      if (item.valid && item.ready) begin
        frame_results_q.push_back(deframe_item(item.opcode, item.rx_byte));
      end
      if (result.valid && result.ready) begin
        if (frame_results_q.size() == 0) begin
          report("result with no item pending", 8'd1, 8'd0);
        end else begin
          want = frame_results_q.pop_front();
          if (want.frame_done) frames_done++;
          if (want.frame_dropped) frames_dropped++;
          if (result.byte_stored !== want.byte_stored)
            report("byte_stored", result.byte_stored, want.byte_stored);
          if (result.store_index !== want.store_index)
            report("store_index", result.store_index, want.store_index);
          if (result.stored_byte !== want.stored_byte)
            report("stored_byte", result.stored_byte, want.stored_byte);
          if (result.frame_done !== want.frame_done)
            report("frame_done", result.frame_done, want.frame_done);
          if (result.frame_dropped !== want.frame_dropped)
            report("frame_dropped", result.frame_dropped, want.frame_dropped);
          if (result.ignored_busy !== want.ignored_busy)
            report("ignored_busy", result.ignored_busy, want.ignored_busy);
          if (result.in_frame !== want.in_frame)
            report("in_frame", result.in_frame, want.in_frame);
        end
      end
    end
    outstanding = frame_results_q.size();
  end

endmodule

/* bench/sync_length_frame_receiver_tb.sv */
`timescale 1ns / 100ps
module sync_length_frame_receiver_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 48;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  slfr_item_if   item();
  slfr_result_if result();
  slfr_cfg_if    cfg();

  int fail_count;
  int outstanding;
  int frames_done;
  int frames_dropped;

  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  logic holding = 1'b0;
  event hold_ev;

  logic [15:0] sync_now = slfr_pkg::SYNC_RESET;

  always #5 clk = ~clk;

  sync_length_frame_receiver DUT (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .cfg(cfg)
  );

  slfr_checker u_checker (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .cfg(cfg),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .frames_done(frames_done),
    .frames_dropped(frames_dropped)
  );

  always @(negedge clk) begin
    result.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      @(hold_ev);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without progress.", IDLE_LIMIT);
      $display("sync_length_frame_receiver regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid <= 1'b1;
    item.opcode <= op;
    item.rx_byte <= b;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_sync(input logic [15:0] w);
    cfg.valid <= 1'b1;
    cfg.data <= w;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    sync_now = w;
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(12);
    if (r < 88) return $urandom_range(61, 62);
    if (r < 94) return $urandom_range(63, 255);
    return $urandom_range(13, 60);
  endfunction

  task automatic send_frame(input int len_val, input int busy_bytes);
    int body;
    body = (len_val + 3 < slfr_pkg::BUF_BYTES_DEF) ? len_val + 3 : slfr_pkg::BUF_BYTES_DEF;
    if ($urandom_range(3) == 0) send_item(slfr_pkg::OP_RELEASE, 8'($urandom));
    send_item(slfr_pkg::OP_BYTE, sync_now[15:8]);
    send_item(slfr_pkg::OP_BYTE, sync_now[7:0]);
    for (int i = 0; i < body; i++) begin
      send_item(slfr_pkg::OP_BYTE,
                (i == slfr_pkg::LENGTH_POS_DEF) ? 8'(len_val) : 8'($urandom));
    end
    repeat (busy_bytes) send_item(slfr_pkg::OP_BYTE, 8'($urandom));
    send_item(slfr_pkg::OP_RELEASE, 8'($urandom));
  endtask

  task automatic random_step();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      send_frame(pick_length(), $urandom_range(2));
    end else if (sel < 80) begin
      send_item(slfr_pkg::OP_BYTE, 8'($urandom));
    end else if (sel < 88) begin
      send_item(slfr_pkg::OP_RELEASE, 8'($urandom));
    end else if (sel < 95) begin
      send_item(slfr_pkg::OP_BYTE, sync_now[15:8]);
      send_item(slfr_pkg::OP_BYTE, 8'($urandom));
    end else begin
      send_item(slfr_pkg::OP_BYTE, sync_now[15:8]);
      send_item(slfr_pkg::OP_BYTE, sync_now[7:0]);
      repeat ($urandom_range(3)) send_item(slfr_pkg::OP_BYTE, 8'($urandom));
      send_item(slfr_pkg::OP_RELEASE, 8'($urandom));
    end
  endtask

  task automatic run_directed();
    send_item(slfr_pkg::OP_RELEASE, 8'hFF);
    send_item(slfr_pkg::OP_BYTE, 8'hAA);
    send_item(slfr_pkg::OP_BYTE, 8'hAF);
    send_item(slfr_pkg::OP_BYTE, 8'h00);
    send_item(slfr_pkg::OP_RELEASE, 8'h00);
    send_item(slfr_pkg::OP_BYTE, 8'h00);
    send_item(slfr_pkg::OP_BYTE, 8'hFF);
    send_item(slfr_pkg::OP_BYTE, 8'h55);
    send_item(slfr_pkg::OP_RELEASE, 8'hAA);
    send_item(slfr_pkg::OP_BYTE, 8'hFF);
    send_item(slfr_pkg::OP_BYTE, 8'hAA);
    send_item(slfr_pkg::OP_BYTE, 8'hAF);
    send_item(slfr_pkg::OP_BYTE, 8'h80);
    send_item(slfr_pkg::OP_BYTE, 8'h01);
    send_item(slfr_pkg::OP_BYTE, 8'h7F);
    send_item(slfr_pkg::OP_BYTE, 8'h33);
    send_item(slfr_pkg::OP_BYTE, 8'h00);
    send_item(slfr_pkg::OP_RELEASE, 8'h00);
    send_item(slfr_pkg::OP_BYTE, 8'hAA);
  endtask

  initial begin
    logic [15:0] sync_tab [PHASES];
    int          idle_tab [PHASES];
    int          stall_tab [PHASES];
    int          target;
    bit          paused;
    sync_tab = '{slfr_pkg::SYNC_RESET, 16'h0000, 16'hFFFF, 16'($urandom),
                 slfr_pkg::SYNC_RESET};
    idle_tab = '{0, 76, 0, 28, 0};
    stall_tab = '{0, 0, 76, 28, 0};
    paused = 1'b0;
    item.valid = 1'b0;
    item.opcode = slfr_pkg::OP_BYTE;
    item.rx_byte = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_sync(sync_tab[p]);
      end
      sender_idle_pct <= idle_tab[p];
      recv_stall_pct <= stall_tab[p];
      if (p == 0) begin
        run_directed();
        -> hold_ev;
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        random_step();
        if (p == 1 && !paused && items_sent > target - ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();

    $display("Sent %0d items across %0d sync words and four idling mixes.", items_sent, PHASES);
    $display("Frames completed: %0d, frames dropped at buffer limit: %0d.",
             frames_done, frames_dropped);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sync_length_frame_receiver regression: pass");
    end else begin
      $display("sync_length_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
